// ===== src/est_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// est_pkg
// Shared constants and types of the event statistics table.
// ----------------------------------------------------------------------------
package est_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	// request command codes
	localparam logic [2:0] CMD_SCOPE   = 3'd0;
	localparam logic [2:0] CMD_COUNTER = 3'd1;
	localparam logic [2:0] CMD_EVENT   = 3'd2;
	localparam logic [2:0] CMD_READ    = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	// response status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_DISABLED = 2'd2;
	localparam logic [1:0] STAT_INVALID  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_DROP,
		ST_FETCH,
		ST_LOAD,
		ST_HITS,
		ST_SUM,
		ST_DUR,
		ST_TSUM,
		ST_MIN,
		ST_MAX,
		ST_WRITE,
		ST_REPLY
	} est_state_t;

	// one slot row of the statistics memory
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] hits;
		logic [63:0] sum;
		logic [63:0] tsum;
		logic [63:0] tmin;
		logic [63:0] tmax;
		logic        min_valid;
	} est_rec_t;

endpackage
`default_nettype wire

// ===== src/est_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// est_req_if
// Request channel of the event statistics table.
// ----------------------------------------------------------------------------
interface est_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic [31:0]        name_key;
	logic signed [63:0] amount;
	logic [63:0]        start_time;
	logic [63:0]        end_time;
	logic [5:0]         slot_select;

	modport source (
		output valid, command, name_key, amount, start_time, end_time, slot_select,
		input  ready
	);
	modport sink (
		input  valid, command, name_key, amount, start_time, end_time, slot_select,
		output ready
	);
endinterface
`default_nettype wire

// ===== src/est_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// est_rsp_if
// Response channel of the event statistics table.
// ----------------------------------------------------------------------------
interface est_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [5:0]         slot_index;
	logic [1:0]         slot_kind;
	logic [63:0]        hit_count;
	logic signed [63:0] signed_total;
	logic [63:0]        time_total;
	logic [63:0]        time_min;
	logic [63:0]        time_max;
	logic [6:0]         used_slots;
	logic [63:0]        dropped_count;

	modport source (
		output valid, status, slot_index, slot_kind, hit_count, signed_total,
		       time_total, time_min, time_max, used_slots, dropped_count,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, slot_kind, hit_count, signed_total,
		       time_total, time_min, time_max, used_slots, dropped_count,
		output ready
	);
endinterface
`default_nettype wire

// ===== src/event_statistics_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// event_statistics_table_core
// Statistics table of up to 64 slots keyed by a 32-bit name key. A record
// request (scope, counter, event) looks up its key among the claimed slots,
// lowest index first, claims the next free slot on a miss, or counts an
// overflow when the table is full; a read request returns one slot; a clear
// request empties the table and the overflow count. Records are ignored while
// the enable register is low. One request is in flight at a time: ready is
// high only while the sequencer is idle. A clear, an invalid request or a
// disabled record answers straight from dispatch; a read fetches and loads
// its slot, then replies; a record searches the claimed slots one by one,
// then counts an overflow when the table is full, or fetches a matched
// slot, then takes 2 update steps for counter and event records or 5 for
// scope records, and one write-back. The key search reads one key per
// cycle from the key memory, and the single 64-bit add/subtract unit
// performs every count, sum, duration and min/max compare one after another.
// A finished response sits in an output register, so the next request is
// taken while it waits; the sequencer holds only at its final step.
// ----------------------------------------------------------------------------
module event_statistics_table_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	est_req_if.sink   req,
	est_rsp_if.source rsp
);
	import est_pkg::*;

	est_state_t state_q, next_state;

	// captured request
	logic [2:0]         cmd_q;
	logic [31:0]        key_q;
	logic [63:0]        amount_q;
	logic [63:0]        t0_q;
	logic [63:0]        t1_q;
	logic [IDX_W-1:0]   sel_q;

	logic               enabled_q;
	logic [CNT_W-1:0]   claimed_q, claimed_d;
	logic [63:0]        overflow_q, overflow_d;

	// key search
	logic [CNT_W-1:0]   scan_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic [31:0]        key_rd_q;
	logic               issue, hit;

	// working copy of the slot under update
	logic [IDX_W-1:0]   slot_q;
	logic [1:0]         w_kind_q;
	logic [63:0]        w_hits_q, w_sum_q, w_tsum_q, w_min_q, w_max_q, dur_q;
	logic               w_minv_q;

	// memories
	logic [31:0]        key_mem [MAX_SLOTS];
	est_rec_t           rec_mem [MAX_SLOTS];
	est_rec_t           rec_rd_q, rec_wdata;
	logic               key_we, key_re, rec_we, rec_re;

	// shared add/subtract unit
	logic [63:0]        alu_a, alu_b;
	logic               alu_sub;
	logic [64:0]        alu_sum;
	logic [63:0]        alu_res;
	logic               alu_carry;

	// response staging
	logic               out_free;
	logic               emit_en, emit_slot;
	logic [1:0]         emit_status;
	logic               out_valid_q;
	logic [1:0]         out_status_q, out_kind_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [63:0]        out_hits_q, out_sum_q, out_tsum_q, out_min_q, out_max_q;
	logic [CNT_W-1:0]   out_used_q;
	logic [63:0]        out_dropped_q;

	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	// a carry out of a subtraction means a >= b
	assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {64'd0, alu_sub};
	assign alu_res   = alu_sum[63:0];
	assign alu_carry = alu_sum[64];

	assign issue = (scan_q < claimed_q);
	assign hit   = pend_q && (key_rd_q == key_q);

	assign rec_wdata = '{kind: w_kind_q, hits: w_hits_q, sum: w_sum_q, tsum: w_tsum_q,
		tmin: w_min_q, tmax: w_max_q, min_valid: w_minv_q};

	// ------------------------------------------------------------------
	// Sequencer: next state, unit operands, memory strobes, response
	// ------------------------------------------------------------------
	always_comb begin
		next_state  = state_q;
		claimed_d   = claimed_q;
		overflow_d  = overflow_q;
		alu_a       = w_hits_q;
		alu_b       = 64'd1;
		alu_sub     = 1'b0;
		key_we      = 1'b0;
		key_re      = 1'b0;
		rec_we      = 1'b0;
		rec_re      = 1'b0;
		emit_en     = 1'b0;
		emit_slot   = 1'b0;
		emit_status = STAT_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					next_state = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (cmd_q == CMD_CLEAR) begin
					if (out_free) begin
						claimed_d  = '0;
						overflow_d = '0;
						emit_en    = 1'b1;
						next_state = ST_IDLE;
					end
				end else if (cmd_q == CMD_READ) begin
					if ({1'b0, sel_q} >= claimed_q) begin
						if (out_free) begin
							emit_en     = 1'b1;
							emit_status = STAT_INVALID;
							next_state  = ST_IDLE;
						end
					end else begin
						next_state = ST_FETCH;
					end
				end else if (cmd_q > CMD_CLEAR) begin
					if (out_free) begin
						emit_en     = 1'b1;
						emit_status = STAT_INVALID;
						next_state  = ST_IDLE;
					end
				end else if (!enabled_q) begin
					if (out_free) begin
						emit_en     = 1'b1;
						emit_status = STAT_DISABLED;
						next_state  = ST_IDLE;
					end
				end else begin
					next_state = ST_SCAN;
				end
			end
			ST_SCAN: begin
				key_re = issue && !hit;
				priority if (hit) begin
					next_state = ST_FETCH;
				end else if (!issue) begin
					// no match among the claimed slots
					if (claimed_q == CNT_W'(MAX_SLOTS)) begin
						next_state = ST_DROP;
					end else begin
						key_we     = 1'b1;
						claimed_d  = claimed_q + 1'b1;
						next_state = ST_HITS;
					end
				end else begin
					next_state = ST_SCAN;
				end
			end
			ST_DROP: begin
				alu_a = overflow_q;
				alu_b = 64'd1;
				if (out_free) begin
					overflow_d  = alu_res;
					emit_en     = 1'b1;
					emit_status = STAT_FULL;
					next_state  = ST_IDLE;
				end
			end
			ST_FETCH: begin
				rec_re     = 1'b1;
				next_state = ST_LOAD;
			end
			ST_LOAD: begin
				next_state = (cmd_q == CMD_READ) ? ST_REPLY : ST_HITS;
			end
			ST_HITS: begin
				alu_a      = w_hits_q;
				alu_b      = 64'd1;
				next_state = (cmd_q == CMD_SCOPE) ? ST_DUR : ST_SUM;
			end
			ST_SUM: begin
				alu_a      = w_sum_q;
				alu_b      = amount_q;
				next_state = ST_WRITE;
			end
			ST_DUR: begin
				alu_a      = t1_q;
				alu_b      = t0_q;
				alu_sub    = 1'b1;
				next_state = ST_TSUM;
			end
			ST_TSUM: begin
				alu_a      = w_tsum_q;
				alu_b      = dur_q;
				next_state = ST_MIN;
			end
			ST_MIN: begin
				alu_a      = dur_q;
				alu_b      = w_min_q;
				alu_sub    = 1'b1;
				next_state = ST_MAX;
			end
			ST_MAX: begin
				alu_a      = w_max_q;
				alu_b      = dur_q;
				alu_sub    = 1'b1;
				next_state = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) begin
					rec_we     = 1'b1;
					emit_en    = 1'b1;
					emit_slot  = 1'b1;
					next_state = ST_IDLE;
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					emit_en    = 1'b1;
					emit_slot  = 1'b1;
					next_state = ST_IDLE;
				end
			end
			default: begin
				next_state = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enabled_q   <= 1'b0;
			claimed_q   <= '0;
			overflow_q  <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= next_state;
			claimed_q  <= claimed_d;
			overflow_q <= overflow_d;
			if (cfg_we) begin
				enabled_q <= cfg_wdata;
			end
			// restart the search at slot zero for each request
			if (state_q == ST_DISPATCH) begin
				scan_q <= '0;
				pend_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				pend_q <= key_re;
				if (key_re) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q    <= req.command;
			key_q    <= req.name_key;
			amount_q <= req.amount;
			t0_q     <= req.start_time;
			t1_q     <= req.end_time;
			sel_q    <= req.slot_select;
		end
		if (state_q == ST_SCAN && key_re) begin
			pend_idx_q <= scan_q[IDX_W-1:0];
		end
		unique case (state_q)
			ST_DISPATCH: begin
				slot_q <= sel_q;
			end
			ST_SCAN: begin
				if (hit) begin
					slot_q <= pend_idx_q;
				end else if (!issue) begin
					// claim: type the slot and zero its statistics
					slot_q   <= claimed_q[IDX_W-1:0];
					w_kind_q <= cmd_q[1:0];
					w_hits_q <= '0;
					w_sum_q  <= '0;
					w_tsum_q <= '0;
					w_min_q  <= '0;
					w_max_q  <= '0;
					w_minv_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				w_kind_q <= rec_rd_q.kind;
				w_hits_q <= rec_rd_q.hits;
				w_sum_q  <= rec_rd_q.sum;
				w_tsum_q <= rec_rd_q.tsum;
				w_min_q  <= rec_rd_q.tmin;
				w_max_q  <= rec_rd_q.tmax;
				w_minv_q <= rec_rd_q.min_valid;
			end
			ST_HITS: w_hits_q <= alu_res;
			ST_SUM:  w_sum_q  <= alu_res;
			ST_DUR:  dur_q    <= alu_carry ? alu_res : 64'd0;
			ST_TSUM: w_tsum_q <= alu_res;
			ST_MIN: begin
				// borrow means the new duration is below the stored minimum
				if (!w_minv_q || !alu_carry) begin
					w_min_q  <= dur_q;
					w_minv_q <= 1'b1;
				end
			end
			ST_MAX: begin
				if (!alu_carry) begin
					w_max_q <= dur_q;
				end
			end
			default: begin
			end
		endcase
		if (emit_en) begin
			out_status_q  <= emit_status;
			out_used_q    <= claimed_d;
			out_dropped_q <= overflow_d;
			out_index_q   <= emit_slot ? slot_q   : '0;
			out_kind_q    <= emit_slot ? w_kind_q : 2'd0;
			out_hits_q    <= emit_slot ? w_hits_q : 64'd0;
			out_sum_q     <= emit_slot ? w_sum_q  : 64'd0;
			out_tsum_q    <= emit_slot ? w_tsum_q : 64'd0;
			out_min_q     <= (emit_slot && w_minv_q) ? w_min_q : 64'd0;
			out_max_q     <= emit_slot ? w_max_q  : 64'd0;
		end
	end

	// ------------------------------------------------------------------
	// Key and slot memories, registered reads
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[claimed_q[IDX_W-1:0]] <= key_q;
		end
		if (key_re) begin
			key_rd_q <= key_mem[scan_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[slot_q] <= rec_wdata;
		end
		if (rec_re) begin
			rec_rd_q <= rec_mem[slot_q];
		end
	end

	// ------------------------------------------------------------------
	// Response port
	// ------------------------------------------------------------------
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.slot_index    = out_index_q;
	assign rsp.slot_kind     = out_kind_q;
	assign rsp.hit_count     = out_hits_q;
	assign rsp.signed_total  = out_sum_q;
	assign rsp.time_total    = out_tsum_q;
	assign rsp.time_min      = out_min_q;
	assign rsp.time_max      = out_max_q;
	assign rsp.used_slots    = out_used_q;
	assign rsp.dropped_count = out_dropped_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_claimed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		claimed_q <= CNT_W'(MAX_SLOTS))
		else $error("claimed slot count beyond table size");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_DISPATCH))
		else $error("accepted request not dispatched");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DROP) |-> (claimed_q == CNT_W'(MAX_SLOTS)))
		else $error("overflow counted with free slots");

	a_write_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> ({1'b0, slot_q} < claimed_q))
		else $error("write-back to an unclaimed slot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> (!out_valid_q || rsp.ready))
		else $error("response overwritten before taken");

endmodule
`default_nettype wire
